/* hdl/psnp_pkg.sv */
// Shared types, widths and codes for the point-to-segment nearest point core.
// Used by every module of the core; depends on nothing else.
package psnp_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 1;
    localparam int LEN_W      = PROD_W;
    localparam int HALF_W     = LEN_W / 2;
    localparam int NUM_W      = DIFF_W + LEN_W;
    localparam int DEN_W      = LEN_W + 1;
    localparam int QUO_W      = 62;
    localparam int REM0_W     = NUM_W - QUO_W;
    localparam int PX_W       = 64;
    localparam int SQ_W       = LEN_W;
    localparam int SQ_PAD_W   = SQ_W + 2;
    localparam int ROOT_W     = SQ_PAD_W / 2;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int DIV_CELLS  = QUO_W;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 3'd4;

    localparam logic [1:0] WHERE_PROJ  = 2'd0;
    localparam logic [1:0] WHERE_START = 2'd1;
    localparam logic [1:0] WHERE_END   = 2'd2;
    localparam logic [1:0] WHERE_MID   = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic                         clamp_to_segment;
    } psnp_req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic [COORD_BITS-1:0]        distance;
        logic [1:0]                   where_found;
    } psnp_res_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] nq;
    } psnp_div_lane_t;

    typedef struct packed {
        psnp_req_t query;
        logic      deg;
        logic      end_near;
        logic      neg_x;
        logic      neg_y;
        logic      ov_x;
        logic      ov_y;
    } psnp_div_side_t;

    typedef struct packed {
        logic [SREM_W-1:0]   rem;
        logic [SQ_PAD_W-1:0] rest;
        logic [ROOT_W-1:0]   root;
    } psnp_sqrt_lane_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic [1:0]                   where_found;
    } psnp_sqrt_side_t;

endpackage

/* hdl/psnp_div_cell.sv */
// One cell of the projection divider chain: one quotient bit for each axis.
// Depends on psnp_pkg.
module psnp_div_cell
    import psnp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [DEN_W-1:0] den,
    input  psnp_div_lane_t in_x,
    input  psnp_div_lane_t in_y,
    input  psnp_div_side_t in_side,
    output logic           out_valid,
    output psnp_div_lane_t out_x,
    output psnp_div_lane_t out_y,
    output psnp_div_side_t out_side
);

    function automatic psnp_div_lane_t div_step(psnp_div_lane_t lane, logic [DEN_W-1:0] d);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        psnp_div_lane_t r;
        trial = {lane.rem, lane.nq[QUO_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
        begin
            r.rem = diff[DEN_W-1:0];
            r.nq  = {lane.nq[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DEN_W-1:0];
            r.nq  = {lane.nq[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic           valid_reg;
    psnp_div_lane_t x_reg;
    psnp_div_lane_t y_reg;
    psnp_div_side_t side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= div_step(in_x, den);
        y_reg    <= div_step(in_y, den);
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/psnp_sqrt_cell.sv */
// One cell of the distance square root chain: one root bit per cell.
// Depends on psnp_pkg.
module psnp_sqrt_cell
    import psnp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  psnp_sqrt_lane_t in_lane,
    input  psnp_sqrt_side_t in_side,
    output logic            out_valid,
    output psnp_sqrt_lane_t out_lane,
    output psnp_sqrt_side_t out_side
);

    logic            valid_reg;
    psnp_sqrt_lane_t lane_reg;
    psnp_sqrt_side_t side_reg;
    psnp_sqrt_lane_t lane_next;
    logic [SREM_W+1:0] part;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;

    always_comb
    begin
        part  = {in_lane.rem, in_lane.rest[SQ_PAD_W-1 -: 2]};
        trial = {2'b00, in_lane.root, 2'b01};
        diff  = part - trial;
        lane_next.rest = {in_lane.rest[SQ_PAD_W-3:0], 2'b00};
        if (part >= trial)
        begin
            lane_next.rem  = diff[SREM_W-1:0];
            lane_next.root = {in_lane.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = part[SREM_W-1:0];
            lane_next.root = {in_lane.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;

endmodule

/* hdl/point_segment_nearest_point_core.sv */
// Nearest point on a configured segment with the distance to it.
// One request is taken every cycle; busy stays low, and the 62-cell divider
// and 34-cell root chains lie on the path from each accepted request to its done strobe. Reset clears the pipeline and
// loads the segment registers with their reset values. Results cannot stall.
// Depends on psnp_pkg, psnp_div_cell and psnp_sqrt_cell.
module point_segment_nearest_point_core
    import psnp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psnp_req_t            req,
    output logic                 done,
    output psnp_res_t            res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic signed [PX_W-1:0] COORD_MAX = PX_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [PX_W-1:0] COORD_MIN = -COORD_MAX - 64'sd1;
    localparam logic [PX_W-1:0]        OV_MAG    = 64'h4000_0000_0000_0000;

    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;
    logic [31:0]                  min_len_reg;

    logic take;

    logic      v0_reg;
    psnp_req_t s0_q_reg;

    logic                     v1_reg;
    psnp_req_t                s1_q_reg;
    logic signed [DIFF_W-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg;

    logic                     v2_reg;
    psnp_req_t                s2_q_reg;
    logic signed [PROD_W-1:0] s2_pdx_reg, s2_pdy_reg, s2_lx_reg, s2_ly_reg;
    logic signed [PROD_W-1:0] s2_a2x_reg, s2_a2y_reg, s2_b2x_reg, s2_b2y_reg;
    logic signed [DIFF_W-1:0] s2_dx_reg, s2_dy_reg;

    logic                    v3_reg;
    psnp_req_t               s3_q_reg;
    logic signed [DOT_W-1:0] s3_dot_reg;
    logic [LEN_W-1:0]        s3_len_reg;
    logic                    s3_end_near_reg;
    logic [DIFF_W-1:0]       s3_mdx_reg, s3_mdy_reg;
    logic                    s3_sdx_reg, s3_sdy_reg;
    logic signed [DIFF_W-1:0] s2_mdx_abs, s2_mdy_abs;
    logic signed [DOT_W-1:0]  s3_dot_abs;

    logic              v4_reg;
    psnp_div_side_t    s4_side_reg;
    logic [LEN_W-1:0]  s4_dotm_reg;
    logic [LEN_W-1:0]  s4_len_reg;
    logic [DIFF_W-1:0] s4_mdx_reg, s4_mdy_reg;

    logic              v5_reg;
    psnp_div_side_t    s5_side_reg;
    logic [PROD_W-1:0] s5_xlo_reg, s5_xhi_reg, s5_ylo_reg, s5_yhi_reg;
    logic [LEN_W-1:0]  s5_len_reg;

    logic              v6_reg;
    psnp_div_side_t    s6_side_reg;
    logic [NUM_W-1:0]  s6_numx_reg, s6_numy_reg;
    logic [DEN_W-1:0]  s6_den_reg;

    logic              v7_reg;
    psnp_div_side_t    s7_side_reg;
    psnp_div_lane_t    s7_x_reg, s7_y_reg;
    logic [DEN_W-1:0]  s7_den_reg;
    logic [REM0_W-1:0] s6_remx, s6_remy;

    logic           dv  [0:DIV_CELLS];
    psnp_div_lane_t dlx [0:DIV_CELLS];
    psnp_div_lane_t dly [0:DIV_CELLS];
    psnp_div_side_t dsd [0:DIV_CELLS];

    psnp_div_side_t            dq_side;
    logic [PX_W-1:0]           mag_x, mag_y;
    logic signed [PX_W-1:0]    sx64, sy64, ex64, ey64, px, py;
    logic signed [PX_W-1:0]    lo_x, hi_x, lo_y, hi_y;
    logic signed [DIFF_W-1:0]  mid_x_sum, mid_y_sum;
    logic                      outside;
    psnp_sqrt_side_t           sd_side_next;

    logic              vd_reg;
    psnp_sqrt_side_t   sd_side_reg;
    psnp_req_t         sd_q_reg;

    logic                     ve_reg;
    psnp_sqrt_side_t          se_side_reg;
    logic signed [DIFF_W-1:0] se_ex_reg, se_ey_reg;

    logic                     vf_reg;
    psnp_sqrt_side_t          sf_side_reg;
    logic signed [PROD_W-1:0] sf_sx_reg, sf_sy_reg;

    logic            vg_reg;
    psnp_sqrt_side_t sg_side_reg;
    psnp_sqrt_lane_t sg_lane_reg;

    logic            qv  [0:SQRT_CELLS];
    psnp_sqrt_lane_t qln [0:SQRT_CELLS];
    psnp_sqrt_side_t qsd [0:SQRT_CELLS];

    logic      done_reg;
    psnp_res_t res_reg;
    psnp_sqrt_lane_t last_lane;
    psnp_sqrt_side_t last_side;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            min_len_reg <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                REG_MIN_LEN: min_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= take;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            vd_reg   <= dv[DIV_CELLS];
            ve_reg   <= vd_reg;
            vf_reg   <= ve_reg;
            vg_reg   <= vf_reg;
            done_reg <= qv[SQRT_CELLS];
        end
    end

    always_comb
    begin
        s2_mdx_abs = s2_dx_reg[DIFF_W-1] ? -s2_dx_reg : s2_dx_reg;
        s2_mdy_abs = s2_dy_reg[DIFF_W-1] ? -s2_dy_reg : s2_dy_reg;
        s3_dot_abs = s3_dot_reg[DOT_W-1] ? -s3_dot_reg : s3_dot_reg;
        s6_remx    = s6_numx_reg[NUM_W-1:QUO_W];
        s6_remy    = s6_numy_reg[NUM_W-1:QUO_W];
    end

    always_ff @(posedge clk)
    begin
        s0_q_reg <= req;

        s1_q_reg  <= s0_q_reg;
        s1_ax_reg <= {s0_q_reg.query_x[COORD_BITS-1], s0_q_reg.query_x}
                     - {start_x_reg[COORD_BITS-1], start_x_reg};
        s1_ay_reg <= {s0_q_reg.query_y[COORD_BITS-1], s0_q_reg.query_y}
                     - {start_y_reg[COORD_BITS-1], start_y_reg};
        s1_bx_reg <= {s0_q_reg.query_x[COORD_BITS-1], s0_q_reg.query_x}
                     - {end_x_reg[COORD_BITS-1], end_x_reg};
        s1_by_reg <= {s0_q_reg.query_y[COORD_BITS-1], s0_q_reg.query_y}
                     - {end_y_reg[COORD_BITS-1], end_y_reg};
        s1_dx_reg <= {end_x_reg[COORD_BITS-1], end_x_reg}
                     - {start_x_reg[COORD_BITS-1], start_x_reg};
        s1_dy_reg <= {end_y_reg[COORD_BITS-1], end_y_reg}
                     - {start_y_reg[COORD_BITS-1], start_y_reg};

        s2_q_reg   <= s1_q_reg;
        s2_pdx_reg <= s1_ax_reg * s1_dx_reg;
        s2_pdy_reg <= s1_ay_reg * s1_dy_reg;
        s2_lx_reg  <= s1_dx_reg * s1_dx_reg;
        s2_ly_reg  <= s1_dy_reg * s1_dy_reg;
        s2_a2x_reg <= s1_ax_reg * s1_ax_reg;
        s2_a2y_reg <= s1_ay_reg * s1_ay_reg;
        s2_b2x_reg <= s1_bx_reg * s1_bx_reg;
        s2_b2y_reg <= s1_by_reg * s1_by_reg;
        s2_dx_reg  <= s1_dx_reg;
        s2_dy_reg  <= s1_dy_reg;

        s3_q_reg        <= s2_q_reg;
        s3_dot_reg      <= s2_pdx_reg + s2_pdy_reg;
        s3_len_reg      <= s2_lx_reg[LEN_W-1:0] + s2_ly_reg[LEN_W-1:0];
        s3_end_near_reg <= (s2_b2x_reg[LEN_W-1:0] + s2_b2y_reg[LEN_W-1:0])
                           < (s2_a2x_reg[LEN_W-1:0] + s2_a2y_reg[LEN_W-1:0]);
        s3_mdx_reg      <= s2_mdx_abs;
        s3_mdy_reg      <= s2_mdy_abs;
        s3_sdx_reg      <= s2_dx_reg[DIFF_W-1];
        s3_sdy_reg      <= s2_dy_reg[DIFF_W-1];

        s4_side_reg.query    <= s3_q_reg;
        s4_side_reg.deg      <= (s3_len_reg == '0)
                                || (s3_len_reg < {{(LEN_W - 32){1'b0}}, min_len_reg});
        s4_side_reg.end_near <= s3_end_near_reg;
        s4_side_reg.neg_x    <= s3_sdx_reg ^ s3_dot_reg[DOT_W-1];
        s4_side_reg.neg_y    <= s3_sdy_reg ^ s3_dot_reg[DOT_W-1];
        s4_side_reg.ov_x     <= 1'b0;
        s4_side_reg.ov_y     <= 1'b0;
        s4_dotm_reg          <= s3_dot_abs[LEN_W-1:0];
        s4_len_reg           <= s3_len_reg;
        s4_mdx_reg           <= s3_mdx_reg;
        s4_mdy_reg           <= s3_mdy_reg;

        s5_side_reg <= s4_side_reg;
        s5_xlo_reg  <= s4_mdx_reg * s4_dotm_reg[HALF_W-1:0];
        s5_xhi_reg  <= s4_mdx_reg * s4_dotm_reg[LEN_W-1:HALF_W];
        s5_ylo_reg  <= s4_mdy_reg * s4_dotm_reg[HALF_W-1:0];
        s5_yhi_reg  <= s4_mdy_reg * s4_dotm_reg[LEN_W-1:HALF_W];
        s5_len_reg  <= s4_len_reg;

        s6_side_reg <= s5_side_reg;
        s6_numx_reg <= NUM_W'({s5_xhi_reg, {(HALF_W + 1){1'b0}}})
                       + NUM_W'({s5_xlo_reg, 1'b0}) + NUM_W'(s5_len_reg);
        s6_numy_reg <= NUM_W'({s5_yhi_reg, {(HALF_W + 1){1'b0}}})
                       + NUM_W'({s5_ylo_reg, 1'b0}) + NUM_W'(s5_len_reg);
        s6_den_reg  <= {s5_len_reg, 1'b0};

        s7_side_reg.query    <= s6_side_reg.query;
        s7_side_reg.deg      <= s6_side_reg.deg;
        s7_side_reg.end_near <= s6_side_reg.end_near;
        s7_side_reg.neg_x    <= s6_side_reg.neg_x;
        s7_side_reg.neg_y    <= s6_side_reg.neg_y;
        s7_side_reg.ov_x     <= DEN_W'(s6_remx) >= s6_den_reg;
        s7_side_reg.ov_y     <= DEN_W'(s6_remy) >= s6_den_reg;
        s7_x_reg.rem         <= DEN_W'(s6_remx);
        s7_x_reg.nq          <= s6_numx_reg[QUO_W-1:0];
        s7_y_reg.rem         <= DEN_W'(s6_remy);
        s7_y_reg.nq          <= s6_numy_reg[QUO_W-1:0];
        s7_den_reg           <= s6_den_reg;
    end

    assign dv[0]  = v7_reg;
    assign dlx[0] = s7_x_reg;
    assign dly[0] = s7_y_reg;
    assign dsd[0] = s7_side_reg;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        psnp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[i]),
            .den       (s7_den_reg),
            .in_x      (dlx[i]),
            .in_y      (dly[i]),
            .in_side   (dsd[i]),
            .out_valid (dv[i+1]),
            .out_x     (dlx[i+1]),
            .out_y     (dly[i+1]),
            .out_side  (dsd[i+1])
        );
    end

    always_comb
    begin
        dq_side   = dsd[DIV_CELLS];
        sx64      = PX_W'(start_x_reg);
        sy64      = PX_W'(start_y_reg);
        ex64      = PX_W'(end_x_reg);
        ey64      = PX_W'(end_y_reg);
        mag_x     = dq_side.ov_x ? OV_MAG : PX_W'(dlx[DIV_CELLS].nq);
        mag_y     = dq_side.ov_y ? OV_MAG : PX_W'(dly[DIV_CELLS].nq);
        px        = dq_side.neg_x ? sx64 - $signed(mag_x) : sx64 + $signed(mag_x);
        py        = dq_side.neg_y ? sy64 - $signed(mag_y) : sy64 + $signed(mag_y);
        lo_x      = (sx64 < ex64) ? sx64 : ex64;
        hi_x      = (sx64 > ex64) ? sx64 : ex64;
        lo_y      = (sy64 < ey64) ? sy64 : ey64;
        hi_y      = (sy64 > ey64) ? sy64 : ey64;
        outside   = dq_side.query.clamp_to_segment
                    && (px < lo_x || px > hi_x || py < lo_y || py > hi_y);
        mid_x_sum = {start_x_reg[COORD_BITS-1], start_x_reg}
                    + {end_x_reg[COORD_BITS-1], end_x_reg};
        mid_y_sum = {start_y_reg[COORD_BITS-1], start_y_reg}
                    + {end_y_reg[COORD_BITS-1], end_y_reg};
        priority if (dq_side.deg)
        begin
            sd_side_next.near_x      = mid_x_sum[DIFF_W-1:1];
            sd_side_next.near_y      = mid_y_sum[DIFF_W-1:1];
            sd_side_next.where_found = WHERE_MID;
        end
        else if (outside && dq_side.end_near)
        begin
            sd_side_next.near_x      = end_x_reg;
            sd_side_next.near_y      = end_y_reg;
            sd_side_next.where_found = WHERE_END;
        end
        else if (outside)
        begin
            sd_side_next.near_x      = start_x_reg;
            sd_side_next.near_y      = start_y_reg;
            sd_side_next.where_found = WHERE_START;
        end
        else
        begin
            sd_side_next.near_x      = (px > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                     : (px < COORD_MIN) ? COORD_MIN[COORD_BITS-1:0]
                                     : px[COORD_BITS-1:0];
            sd_side_next.near_y      = (py > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                     : (py < COORD_MIN) ? COORD_MIN[COORD_BITS-1:0]
                                     : py[COORD_BITS-1:0];
            sd_side_next.where_found = WHERE_PROJ;
        end
    end

    always_ff @(posedge clk)
    begin
        sd_side_reg <= sd_side_next;
        sd_q_reg    <= dq_side.query;

        se_side_reg <= sd_side_reg;
        se_ex_reg   <= {sd_side_reg.near_x[COORD_BITS-1], sd_side_reg.near_x}
                       - {sd_q_reg.query_x[COORD_BITS-1], sd_q_reg.query_x};
        se_ey_reg   <= {sd_side_reg.near_y[COORD_BITS-1], sd_side_reg.near_y}
                       - {sd_q_reg.query_y[COORD_BITS-1], sd_q_reg.query_y};

        sf_side_reg <= se_side_reg;
        sf_sx_reg   <= se_ex_reg * se_ex_reg;
        sf_sy_reg   <= se_ey_reg * se_ey_reg;

        sg_side_reg      <= sf_side_reg;
        sg_lane_reg.rem  <= '0;
        sg_lane_reg.root <= '0;
        sg_lane_reg.rest <= SQ_PAD_W'(sf_sx_reg[SQ_W-1:0] + sf_sy_reg[SQ_W-1:0]);
    end

    assign qv[0]  = vg_reg;
    assign qln[0] = sg_lane_reg;
    assign qsd[0] = sg_side_reg;

    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sqrt
        psnp_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (qv[k]),
            .in_lane   (qln[k]),
            .in_side   (qsd[k]),
            .out_valid (qv[k+1]),
            .out_lane  (qln[k+1]),
            .out_side  (qsd[k+1])
        );
    end

    assign last_lane = qln[SQRT_CELLS];
    assign last_side = qsd[SQRT_CELLS];

    always_ff @(posedge clk)
    begin
        res_reg.near_x      <= last_side.near_x;
        res_reg.near_y      <= last_side.near_y;
        res_reg.where_found <= last_side.where_found;
        res_reg.distance    <= (last_lane.root[ROOT_W-1:COORD_BITS] != '0)
                               ? {COORD_BITS{1'b1}} : last_lane.root[COORD_BITS-1:0];
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
